@@ hw/rtl/salru_pkg.sv @@
`timescale 1ns / 1ps

package salru_pkg;

  // table geometry
  localparam int ENTRIES = 256;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int KEY_W   = 32;
  localparam int SIZE_W  = 24;
  localparam int CAP_W   = 32;
  localparam int BYTES_W = 33;
  localparam int EVC_W   = 9;
  localparam int STAT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 32'd1048576;

  // operation and status codes
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_REMOVE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RD,
    S_UNLINK,
    S_APPEND,
    S_FULL_RD,
    S_FULL_DO,
    S_CHECK,
    S_EV_RD,
    S_EV_DO,
    S_DONE
  } state_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_DECIDE,
    CMD_READ_SLOT,
    CMD_UNLINK,
    CMD_APPEND,
    CMD_READ_OLDEST,
    CMD_DROP,
    CMD_OUT
  } dp_cmd_t;

  // datapath status toward the controller
  typedef struct packed {
    logic match;
    logic scan_end;
    logic is_remove;
    logic hit;
    logic oversize;
    logic full;
    logic over;
    logic empty;
  } dp_stat_t;

endpackage

@@ hw/rtl/salru_ram.sv @@
`timescale 1ns / 1ps

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/salru_ctrl.sv @@
`timescale 1ns / 1ps

module salru_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  salru_pkg::dp_stat_t st,
  output salru_pkg::dp_cmd_t  cmd
);

  salru_pkg::state_t state, state_next;

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= salru_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == salru_pkg::CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != salru_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = salru_pkg::CMD_NONE;
    unique case (state)
      salru_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd        = salru_pkg::CMD_LOAD;
          state_next = salru_pkg::S_SCAN;
        end
      end
      salru_pkg::S_SCAN: begin
        cmd = salru_pkg::CMD_SCAN;
        if (st.match || st.scan_end) begin
          state_next = salru_pkg::S_DECIDE;
        end
      end
      salru_pkg::S_DECIDE: begin
        cmd = salru_pkg::CMD_DECIDE;
        if (st.is_remove) begin
          state_next = st.hit ? salru_pkg::S_RD : salru_pkg::S_DONE;
        end else if (st.oversize) begin
          state_next = salru_pkg::S_DONE;
        end else if (st.hit) begin
          state_next = salru_pkg::S_RD;
        end else if (st.full) begin
          state_next = salru_pkg::S_FULL_RD;
        end else begin
          state_next = salru_pkg::S_APPEND;
        end
      end
      salru_pkg::S_RD: begin
        cmd        = salru_pkg::CMD_READ_SLOT;
        state_next = salru_pkg::S_UNLINK;
      end
      salru_pkg::S_UNLINK: begin
        cmd        = salru_pkg::CMD_UNLINK;
        state_next = st.is_remove ? salru_pkg::S_DONE : salru_pkg::S_APPEND;
      end
      salru_pkg::S_APPEND: begin
        cmd        = salru_pkg::CMD_APPEND;
        state_next = salru_pkg::S_CHECK;
      end
      salru_pkg::S_FULL_RD: begin
        cmd        = salru_pkg::CMD_READ_OLDEST;
        state_next = salru_pkg::S_FULL_DO;
      end
      salru_pkg::S_FULL_DO: begin
        cmd        = salru_pkg::CMD_DROP;
        state_next = salru_pkg::S_APPEND;
      end
      salru_pkg::S_CHECK: begin
        state_next = (st.over && !st.empty) ? salru_pkg::S_EV_RD : salru_pkg::S_DONE;
      end
      salru_pkg::S_EV_RD: begin
        cmd        = salru_pkg::CMD_READ_OLDEST;
        state_next = salru_pkg::S_EV_DO;
      end
      salru_pkg::S_EV_DO: begin
        cmd        = salru_pkg::CMD_DROP;
        state_next = salru_pkg::S_CHECK;
      end
      salru_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd        = salru_pkg::CMD_OUT;
          state_next = salru_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = salru_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/salru_dp.sv @@
`timescale 1ns / 1ps

module salru_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  salru_pkg::dp_cmd_t              cmd,
  output salru_pkg::dp_stat_t             st,
  input  logic                            cfg_we,
  input  logic [salru_pkg::CAP_W-1:0]     cfg_data,
  input  logic                            func,
  input  logic [salru_pkg::KEY_W-1:0]     obj_id,
  input  logic [salru_pkg::SIZE_W-1:0]    obj_len,
  output logic                            hit,
  output logic [salru_pkg::STAT_W-1:0]    status,
  output logic [salru_pkg::EVC_W-1:0]     evicted_count,
  output logic [31:0]                     used_bytes
);

  localparam int IW = salru_pkg::IDX_W;
  localparam int CW = salru_pkg::CNT_W;
  localparam int BW = salru_pkg::BYTES_W;

  // control state
  logic [salru_pkg::CAP_W-1:0]  capacity;
  logic [salru_pkg::ENTRIES-1:0] valid;
  logic [IW-1:0]                oldest;
  logic [IW-1:0]                newest;
  logic [CW-1:0]                count;
  logic [BW-1:0]                bytes_use;
  logic [CW-1:0]                scan_idx;

  // item registers
  logic                         func_r;
  logic [salru_pkg::KEY_W-1:0]  id_r;
  logic [salru_pkg::SIZE_W-1:0] size_r;
  logic                         hit_r;
  logic [IW-1:0]                slot_r;
  logic [salru_pkg::STAT_W-1:0] status_r;
  logic [salru_pkg::EVC_W-1:0]  evicted;
  logic                         st_free_seen;

  // memory ports
  logic                         key_we, bytes_we, newer_we, older_we;
  logic [IW-1:0]                key_wa, bytes_wa, newer_wa, older_wa;
  logic [IW-1:0]                key_ra, link_ra;
  logic [salru_pkg::KEY_W-1:0]  key_rd;
  logic [salru_pkg::SIZE_W-1:0] bytes_rd;
  logic [IW-1:0]                newer_rd, older_rd;
  logic [IW-1:0]                newer_wd, older_wd;

  logic [IW-1:0] prev_idx;
  logic          pend;
  logic [BW-1:0] size_ext, rd_ext;

  salru_ram #(.WIDTH(salru_pkg::KEY_W), .DEPTH(salru_pkg::ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(id_r),
    .raddr(key_ra), .rdata(key_rd)
  );
  salru_ram #(.WIDTH(salru_pkg::SIZE_W), .DEPTH(salru_pkg::ENTRIES)) u_bytes (
    .clk(clk), .we(bytes_we), .waddr(bytes_wa), .wdata(size_r),
    .raddr(link_ra), .rdata(bytes_rd)
  );
  salru_ram #(.WIDTH(IW), .DEPTH(salru_pkg::ENTRIES)) u_newer (
    .clk(clk), .we(newer_we), .waddr(newer_wa), .wdata(newer_wd),
    .raddr(link_ra), .rdata(newer_rd)
  );
  salru_ram #(.WIDTH(IW), .DEPTH(salru_pkg::ENTRIES)) u_older (
    .clk(clk), .we(older_we), .waddr(older_wa), .wdata(older_wd),
    .raddr(link_ra), .rdata(older_rd)
  );

  // scan compares the key read for the previous index
  assign pend     = (scan_idx != '0);
  assign prev_idx = IW'(scan_idx - CW'(1));
  assign size_ext = {{(BW-salru_pkg::SIZE_W){1'b0}}, size_r};
  assign rd_ext   = {{(BW-salru_pkg::SIZE_W){1'b0}}, bytes_rd};

  assign st.match     = pend && valid[prev_idx] && (key_rd == id_r);
  assign st.scan_end  = (scan_idx == CW'(salru_pkg::ENTRIES));
  assign st.is_remove = (func_r == salru_pkg::FUNC_REMOVE);
  assign st.hit       = hit_r;
  assign st.oversize  = ({{(salru_pkg::CAP_W-salru_pkg::SIZE_W){1'b0}}, size_r} > capacity);
  assign st.full      = (count == CW'(salru_pkg::ENTRIES));
  assign st.over      = (bytes_use > {1'b0, capacity});
  assign st.empty     = (count == '0);

  // memory addressing and writes
  always_comb begin
    key_ra   = scan_idx[IW-1:0];
    link_ra  = (cmd == salru_pkg::CMD_READ_OLDEST) ? oldest : slot_r;
    key_we   = 1'b0;
    key_wa   = slot_r;
    bytes_we = 1'b0;
    bytes_wa = slot_r;
    newer_we = 1'b0;
    newer_wa = older_rd;
    newer_wd = newer_rd;
    older_we = 1'b0;
    older_wa = newer_rd;
    older_wd = older_rd;
    case (cmd)
      salru_pkg::CMD_UNLINK: begin
        bytes_we = !st.is_remove;
        newer_we = (slot_r != oldest);
        older_we = (slot_r != newest);
      end
      salru_pkg::CMD_APPEND: begin
        key_we   = !hit_r;
        bytes_we = !hit_r;
        newer_we = (count != '0);
        newer_wa = newest;
        newer_wd = slot_r;
        older_we = (count != '0);
        older_wa = slot_r;
        older_wd = newest;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= salru_pkg::CAP_RESET;
      valid     <= '0;
      oldest    <= '0;
      newest    <= '0;
      count     <= '0;
      bytes_use <= '0;
      scan_idx  <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      case (cmd)
        salru_pkg::CMD_LOAD: begin
          scan_idx <= '0;
        end
        salru_pkg::CMD_SCAN: begin
          if (!st.match && !st.scan_end) begin
            scan_idx <= scan_idx + CW'(1);
          end
        end
        salru_pkg::CMD_UNLINK: begin
          if (st.is_remove) begin
            bytes_use       <= bytes_use - rd_ext;
            valid[slot_r]   <= 1'b0;
          end else begin
            bytes_use <= bytes_use - rd_ext + size_ext;
          end
          if (slot_r == oldest) begin
            oldest <= newer_rd;
          end
          if (slot_r == newest) begin
            newest <= older_rd;
          end
          count <= count - CW'(1);
        end
        salru_pkg::CMD_APPEND: begin
          if (!hit_r) begin
            valid[slot_r] <= 1'b1;
            bytes_use     <= bytes_use + size_ext;
          end
          if (count == '0) begin
            oldest <= slot_r;
          end
          newest <= slot_r;
          count  <= count + CW'(1);
        end
        salru_pkg::CMD_DROP: begin
          bytes_use     <= bytes_use - rd_ext;
          valid[oldest] <= 1'b0;
          oldest        <= newer_rd;
          count         <= count - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    case (cmd)
      salru_pkg::CMD_LOAD: begin
        func_r   <= func;
        id_r     <= obj_id;
        size_r   <= obj_len;
        hit_r    <= 1'b0;
        status_r <= salru_pkg::ST_OK;
        evicted  <= '0;
      end
      salru_pkg::CMD_SCAN: begin
        if (st.match) begin
          hit_r  <= 1'b1;
          slot_r <= prev_idx;
        end else if (pend && !valid[prev_idx] && !st_free_seen) begin
          // lowest free slot wins: later free slots do not overwrite
          slot_r <= prev_idx;
        end
      end
      salru_pkg::CMD_DECIDE: begin
        if (st.is_remove && !hit_r) begin
          status_r <= salru_pkg::ST_ABSENT;
        end else if (!st.is_remove && st.oversize) begin
          status_r <= salru_pkg::ST_OVERSIZE;
        end
      end
      salru_pkg::CMD_DROP: begin
        slot_r  <= oldest;
        evicted <= evicted + salru_pkg::EVC_W'(1);
      end
      salru_pkg::CMD_OUT: begin
        hit           <= hit_r;
        status        <= status_r;
        evicted_count <= evicted;
        used_bytes    <= bytes_use[31:0];
      end
      default: ;
    endcase
  end

  // first free slot seen during the current scan
  always_ff @(posedge clk) begin
    if (rst) begin
      st_free_seen <= 1'b0;
    end else if (cmd == salru_pkg::CMD_LOAD) begin
      st_free_seen <= 1'b0;
    end else if (cmd == salru_pkg::CMD_SCAN && !st.match && pend && !valid[prev_idx]) begin
      st_free_seen <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/size_aware_lru_cache_core.sv @@
`timescale 1ns / 1ps

// Byte-capacity LRU cache tracker. Each input request carries func (0 request,
// 1 remove), obj_id and obj_len; each one yields exactly one result with hit,
// status, evicted_count and used_bytes.
// Input side: in_valid/in_stall; a request is taken when in_valid is high and
// in_stall is low. One request is worked on at a time.
// Output side: out_valid/out_stall with an output register, so the next
// request is taken while a result still waits.
// The lookup walks the key memory one slot per cycle and stops early on a
// hit; then come the decision and relinking, a read and a drop for each
// evicted entry, and the load of the result. A new request is taken only
// once the previous one has loaded its result and the block is idle again.
// cfg_valid/cfg_ready writes cache_capacity; cfg_ready is always high and
// writes belong to idle periods.
// Reset (rst, synchronous) empties the table, zeroes used bytes and loads
// a capacity of 1048576. A stalled result holds until out_stall drops.

module size_aware_lru_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] obj_id,
  input  logic [23:0] obj_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [1:0]  status,
  output logic [8:0]  evicted_count,
  output logic [31:0] used_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  salru_pkg::dp_cmd_t  cmd;
  salru_pkg::dp_stat_t st;

  assign cfg_ready = 1'b1;

  salru_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .st(st), .cmd(cmd)
  );

  salru_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .func(func), .obj_id(obj_id), .obj_len(obj_len),
    .hit(hit), .status(status), .evicted_count(evicted_count),
    .used_bytes(used_bytes)
  );

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // an absent remove changes nothing
  a_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == salru_pkg::ST_ABSENT) |-> (!hit && evicted_count == '0))
    else $error("absent remove reported a hit or evictions");

  // an oversized request evicts nothing
  a_oversize: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == salru_pkg::ST_OVERSIZE) |-> (evicted_count == '0))
    else $error("oversized request evicted entries");

endmodule

@@ tb/sv/size_aware_lru_cache_checker.sv @@
`timescale 1ns / 1ps

module size_aware_lru_cache_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        func,
  input  logic [31:0] obj_id,
  input  logic [23:0] obj_len,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic [1:0]  status,
  input  logic [8:0]  evicted_count,
  input  logic [31:0] used_bytes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic                         hit;
    logic [salru_pkg::STAT_W-1:0] status;
    logic [salru_pkg::EVC_W-1:0]  evicted;
    logic [31:0]                  used;
  } lru_result_t;

  // shadow cache state, recency list kept oldest first
  logic [salru_pkg::CAP_W-1:0]   shadow_cap;
  logic [salru_pkg::KEY_W-1:0]   lru_keys[$];
  logic [salru_pkg::SIZE_W-1:0]  lru_sizes[$];
  logic [salru_pkg::BYTES_W-1:0] shadow_bytes;
  lru_result_t                   expected_results[$];

  function automatic lru_result_t cache_access(logic op, logic [31:0] id,
                                               logic [23:0] sz);
    lru_result_t r;
    int slot;
    slot = -1;
    foreach (lru_keys[i]) if (lru_keys[i] == id) slot = i;
    r.hit = (slot >= 0);
    r.status = salru_pkg::ST_OK;
    r.evicted = '0;
    if (op == salru_pkg::FUNC_REMOVE) begin
      if (slot >= 0) begin
        shadow_bytes -= lru_sizes[slot];
        lru_keys.delete(slot);
        lru_sizes.delete(slot);
      end else begin
        r.status = salru_pkg::ST_ABSENT;
      end
    end else if (sz > shadow_cap) begin
      r.status = salru_pkg::ST_OVERSIZE;
    end else begin
      if (slot >= 0) begin
        shadow_bytes -= lru_sizes[slot];
        lru_keys.delete(slot);
        lru_sizes.delete(slot);
      end else if (lru_keys.size() >= salru_pkg::ENTRIES) begin
        shadow_bytes -= lru_sizes[0];
        void'(lru_keys.pop_front());
        void'(lru_sizes.pop_front());
        r.evicted++;
      end
      lru_keys.push_back(id);
      lru_sizes.push_back(sz);
      shadow_bytes += sz;
      while (shadow_bytes > shadow_cap && lru_keys.size() > 0) begin
        shadow_bytes -= lru_sizes[0];
        void'(lru_keys.pop_front());
        void'(lru_sizes.pop_front());
        r.evicted++;
      end
    end
    r.used = shadow_bytes[31:0];
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    lru_result_t e;
    if (rst) begin
      shadow_cap <= salru_pkg::CAP_RESET;
      lru_keys.delete();
      lru_sizes.delete();
      shadow_bytes = '0;
      expected_results.delete();
      fail_count <= 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_cap <= cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result hit=%0d status=%0d evicted=%0d used=%0d",
                   $time, hit, status, evicted_count, used_bytes);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e != {hit, status, evicted_count, used_bytes}) begin
            $display("%0t: mismatch expected hit=%0d status=%0d evicted=%0d used=%0d",
                     $time, e.hit, e.status, e.evicted, e.used);
            $display("%0t:          actual   hit=%0d status=%0d evicted=%0d used=%0d",
                     $time, hit, status, evicted_count, used_bytes);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(cache_access(func, obj_id, obj_len));
      pending = expected_results.size();
    end
  end

endmodule

@@ tb/sv/size_aware_lru_cache_core_tb.sv @@
`timescale 1ns / 1ps

module size_aware_lru_cache_core_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = salru_pkg::FUNC_REQUEST;
  logic [31:0] obj_id = '0;
  logic [23:0] obj_len = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [1:0]  status;
  logic [8:0]  evicted_count;
  logic [31:0] used_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  size_aware_lru_cache_core dut (.*);
  size_aware_lru_cache_checker chk (.*);

  // send one request and wait for its acceptance
  task automatic send_request(logic op, logic [31:0] id, logic [23:0] sz);
    repeat ($urandom_range(0, 9)) @(negedge clk);
    func <= op;
    obj_id <= id;
    obj_len <= sz;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // drain, let the block settle, then write the capacity
  task automatic set_capacity(logic [31:0] cap);
    while (pending != 0) @(negedge clk);
    repeat (salru_pkg::ENTRIES * 3 + 20) @(negedge clk);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver holds off for a random wait before taking each result
  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      wait_cycles = $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [31:0] key_pool;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, hits, oversized, absent removal
    send_request(salru_pkg::FUNC_REQUEST, 32'h0, 24'd0);
    send_request(salru_pkg::FUNC_REQUEST, 32'hFFFF_FFFF, 24'd1000);
    send_request(salru_pkg::FUNC_REQUEST, 32'h0, 24'd500);
    send_request(salru_pkg::FUNC_REQUEST, 32'h1234, 24'hFF_FFFF);
    send_request(salru_pkg::FUNC_REMOVE, 32'hDEAD_BEEF, 24'hFF_FFFF);
    send_request(salru_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 24'd0);
    send_request(salru_pkg::FUNC_REQUEST, 32'h5, 24'd1048576);
    send_request(salru_pkg::FUNC_REQUEST, 32'h6, 24'd1);
    set_capacity(32'd0);
    send_request(salru_pkg::FUNC_REQUEST, 32'h7, 24'd0);
    send_request(salru_pkg::FUNC_REQUEST, 32'h8, 24'd1);
    send_request(salru_pkg::FUNC_REMOVE, 32'h7, 24'd0);
    set_capacity(32'hFFFF_FFFF);
    // fill past the table size to force full-table evictions
    for (int i = 0; i < salru_pkg::ENTRIES + 4; i++)
      send_request(salru_pkg::FUNC_REQUEST, 32'h100 + i, 24'hFF_FFFF);
    // lower capacity below used bytes; removal does not evict
    set_capacity(32'd1000);
    send_request(salru_pkg::FUNC_REMOVE, 32'h103, 24'd0);
    send_request(salru_pkg::FUNC_REQUEST, 32'h104, 24'd10);

    // random phases with different capacities and key pools
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_capacity(32'd5000);
        1: set_capacity(32'hFFFF_FFFF);
        2: set_capacity($urandom_range(100, 100000));
        3: set_capacity(32'd0);
        4: set_capacity(32'd1048576);
        default: set_capacity($urandom);
      endcase
      key_pool = (phase == 1) ? 32'd400 : 32'd40;
      for (int i = 0; i < 55; i++) begin
        n = $urandom_range(0, 9);
        if (n == 0)
          send_request(1'($urandom_range(0, 1)), $urandom, 24'($urandom));
        else
          send_request(n < 3, $urandom_range(0, key_pool) ^ (phase << 28),
                       (n == 9) ? 24'($urandom) : 24'($urandom_range(0, 2000)));
        if (i == 50 && phase == 2)
          while (pending != 0) @(negedge clk);
      end
    end

    // drain and settle
    while (pending != 0) @(negedge clk);
    repeat (salru_pkg::ENTRIES * 3 + 20) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/salru_pkg.sv
hw/rtl/salru_ram.sv
hw/rtl/salru_ctrl.sv
hw/rtl/salru_dp.sv
hw/rtl/size_aware_lru_cache_core.sv
tb/sv/size_aware_lru_cache_checker.sv
tb/sv/size_aware_lru_cache_core_tb.sv
